// File: sv/emc_pkg.sv
// Shared widths and constants for the exact mantissa cube block.
package emc_pkg;

  // Port payload widths, fixed by the external item format
  localparam int unsigned SIG_PORT_W  = 53;
  localparam int unsigned CUBE_PORT_W = 54;

  // Register stages from operand intake to result register
  localparam int unsigned NUM_STAGES  = 6;

endpackage

// File: sv/emc_if.sv
// Valid/ready channel interfaces for operands, results and the mode register.
interface emc_sig_if import emc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SIG_PORT_W-1:0] significand;

  modport source (output valid, output significand, input ready);
  modport sink   (input valid, input significand, output ready);
endinterface

interface emc_cube_if import emc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CUBE_PORT_W-1:0] cube_significand;
  logic                   round_overflow;

  modport source (output valid, output cube_significand, output round_overflow,
                  input ready);
  modport sink   (input valid, input cube_significand, input round_overflow,
                  output ready);
endinterface

interface emc_cfg_if ();
  logic valid;
  logic ready;
  logic round_enable;

  modport source (output valid, output round_enable, input ready);
  modport sink   (input valid, input round_enable, output ready);
endinterface

// File: sv/emc_round.sv
// Normalize the exact cube to its leading one and apply round-half-up.
module emc_round #(
  parameter int unsigned SIG_WIDTH = 53
) (
  input  logic [3*SIG_WIDTH-1:0] cube,
  input  logic                   round_enable,
  output logic [SIG_WIDTH:0]     result,
  output logic                   overflow
);

  localparam int unsigned W  = SIG_WIDTH;
  localparam int unsigned CW = 3 * SIG_WIDTH;

  logic [W-1:0] top;
  logic         round_bit;

  // Leading one sits in one of the top three cube bits
  always_comb begin
    if (cube[CW-1]) begin
      top       = cube[CW-1 -: W];
      round_bit = cube[CW-1-W];
    end else if (cube[CW-2]) begin
      top       = cube[CW-2 -: W];
      round_bit = cube[CW-2-W];
    end else begin
      top       = cube[CW-3 -: W];
      round_bit = cube[CW-3-W];
    end
  end

  // Add half an ulp when rounding; a carry out lands on bit W
  assign result   = (W+1)'(top) + (W+1)'(round_enable & round_bit);
  assign overflow = result[W];

endmodule

// File: sv/exact_mantissa_cube_core.sv
// Six-stage pipeline; one request per cycle unless the result stalls. Each
// stage holds while its successor is full and stalled, so bubbles collapse
// and intake continues during an output stall while any stage is empty.
// Stages: partial squares, square sum, cube partial products, two adds, round.
// Reset (rst, synchronous) clears all stage valid bits and sets round_enable to 1.
// The mode register accepts a write every cycle.
module exact_mantissa_cube_core import emc_pkg::*; #(
  parameter int unsigned SIG_WIDTH = 53
) (
  input  logic        clk,
  input  logic        rst,
  emc_sig_if.sink     operand,
  emc_cube_if.source  result,
  emc_cfg_if.sink     cfg
);

  localparam int unsigned W  = SIG_WIDTH;
  localparam int unsigned K  = (SIG_WIDTH + 1) / 2;
  localparam int unsigned CW = 3 * SIG_WIDTH;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;
  logic                  round_enable;

  // Stage registers
  logic [2*(W-K)-1:0] st1_aa;
  logic [2*K-1:0]     st1_bb;
  logic [W-1:0]       st1_ab;
  logic [W-1:0]       st1_sig;
  logic [2*W-1:0]     st2_sq;
  logic [W-1:0]       st2_sig;
  logic [2*K-1:0]     st3_pa [4];
  logic [2*K-1:0]     st3_pb [4];
  logic [CW-1:0]      st4_ta;
  logic [CW-1:0]      st4_tb;
  logic [CW-1:0]      st5_cube;
  logic [W:0]         st6_res;
  logic               st6_ovf;

  logic [W-1:0]       sig_in;
  logic [4*K-1:0]     sq_ext;
  logic [W:0]         round_res;
  logic               round_ovf;

  // Mode register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      round_enable <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      round_enable <= cfg.round_enable;
    end
  end

  // Stage enables: advance a stage when empty or when its successor advances
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || result.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign operand.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= operand.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Force the hidden one and drop bits above the width
  assign sig_in = {1'b1, operand.significand[W-2:0]};

  // Stage 1: partial products of the square
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st1_aa  <= (2*(W-K))'(sig_in[W-1:K]) * (2*(W-K))'(sig_in[W-1:K]);
      st1_bb  <= (2*K)'(sig_in[K-1:0]) * (2*K)'(sig_in[K-1:0]);
      st1_ab  <= W'(sig_in[W-1:K]) * W'(sig_in[K-1:0]);
      st1_sig <= sig_in;
    end
  end

  // Stage 2: sum the square
  always_ff @(posedge clk) begin
    if (en[1]) begin
      st2_sq  <= {st1_aa, st1_bb} + ((2*W)'(st1_ab) << (K + 1));
      st2_sig <= st1_sig;
    end
  end

  // Stage 3: square chunks times both operand halves
  assign sq_ext = (4*K)'(st2_sq);
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 4; j++) begin
        st3_pa[j] <= (2*K)'(sq_ext[j*K +: K]) * (2*K)'(st2_sig[W-1:K]);
        st3_pb[j] <= (2*K)'(sq_ext[j*K +: K]) * (2*K)'(st2_sig[K-1:0]);
      end
    end
  end

  // Stage 4: fold even and odd chunk products per half
  always_ff @(posedge clk) begin
    if (en[3]) begin
      st4_ta <= CW'({st3_pa[2], st3_pa[0]}) + (CW'({st3_pa[3], st3_pa[1]}) << K);
      st4_tb <= CW'({st3_pb[2], st3_pb[0]}) + (CW'({st3_pb[3], st3_pb[1]}) << K);
    end
  end

  // Stage 5: exact cube
  always_ff @(posedge clk) begin
    if (en[4]) begin
      st5_cube <= (st4_ta << K) + st4_tb;
    end
  end

  emc_round #(
    .SIG_WIDTH (SIG_WIDTH)
  ) u_round (
    .cube         (st5_cube),
    .round_enable (round_enable),
    .result       (round_res),
    .overflow     (round_ovf)
  );

  // Stage 6: result register
  always_ff @(posedge clk) begin
    if (en[5]) begin
      st6_res <= round_res;
      st6_ovf <= round_ovf;
    end
  end

  assign result.valid            = vld[NUM_STAGES-1];
  assign result.cube_significand = CUBE_PORT_W'(st6_res);
  assign result.round_overflow   = st6_ovf;

endmodule

// File: sv/emc_checker.sv
// Port-level checks for the exact mantissa cube core, with its bind.
module emc_checker import emc_pkg::*; #(
  parameter int unsigned SIG_WIDTH = 53
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [CUBE_PORT_W-1:0] out_cube,
  input logic                   out_ovf,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic                   cfg_round_enable
);

  logic round_mode;

  // Track the mode register from its write requests
  always_ff @(posedge clk) begin
    if (rst) begin
      round_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      round_mode <= cfg_round_enable;
    end
  end

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cube) && $stable(out_ovf))
    else $error("result changed while stalled");

  // Intake stops only when the pipeline is full behind a stalled result
  a_in_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("operand refused with room in the pipeline");

  // Result is normalized, or exactly 2^W on a rounding carry
  a_normalized: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ovf && out_cube == (CUBE_PORT_W'(1) << SIG_WIDTH)) ||
                  (!out_ovf && out_cube[SIG_WIDTH-1] && (out_cube >> SIG_WIDTH) == '0))
    else $error("result not normalized");

  // Truncation mode never carries out
  a_trunc_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && !round_mode |-> !out_ovf)
    else $error("overflow raised with rounding disabled");

endmodule

bind exact_mantissa_cube_core emc_checker #(
  .SIG_WIDTH (SIG_WIDTH)
) u_emc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (operand.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .out_cube         (result.cube_significand),
  .out_ovf          (result.round_overflow),
  .cfg_valid        (cfg.valid),
  .cfg_ready        (cfg.ready),
  .cfg_round_enable (cfg.round_enable)
);

// File: sim/exact_mantissa_cube_core_tb.sv
// Self-checking testbench for the exact mantissa cube pipeline.
module exact_mantissa_cube_core_tb;
  import emc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIG_W      = SIG_PORT_W;
  localparam int unsigned CUBE_W     = 3 * SIG_W;
  localparam int unsigned CYCLE_MAX  = 400000;
  localparam int unsigned RAND_PHASE = 480;
  localparam int unsigned HOLD_OFF   = 120;

  localparam logic [SIG_W-1:0]       SIG_MIN  = 53'h10_0000_0000_0000;
  localparam logic [SIG_W-1:0]       SIG_MAX  = 53'h1F_FFFF_FFFF_FFFF;
  localparam logic [CUBE_PORT_W-1:0] CUBE_MIN = 54'h10_0000_0000_0000;
  localparam logic [CUBE_PORT_W-1:0] CUBE_TOP = 54'h1F_FFFF_FFFF_FFFD;

  typedef enum logic {
    MODE_TRUNCATE = 1'b0,
    MODE_ROUND    = 1'b1
  } round_mode_t;

  typedef struct packed {
    logic [CUBE_PORT_W-1:0] cube_significand;
    logic                   round_overflow;
  } cube_res_t;

  typedef struct packed {
    logic [SIG_W-1:0] significand;
    logic             typed;
    cube_res_t        want;
  } directed_row_t;

  // Extremes and hidden-bit cases; typed rows hold in both rounding modes
  localparam directed_row_t DIRECTED [8] = '{
    '{SIG_MIN,             1'b1, '{CUBE_MIN, 1'b0}},
    '{53'd0,               1'b1, '{CUBE_MIN, 1'b0}},
    '{SIG_MAX,             1'b1, '{CUBE_TOP, 1'b0}},
    '{SIG_MAX >> 1,        1'b1, '{CUBE_TOP, 1'b0}},
    '{SIG_MIN + 53'd1,     1'b0, '{54'd0, 1'b0}},
    '{53'h15_5555_5555_5555, 1'b0, '{54'd0, 1'b0}},
    '{53'h0A_AAAA_AAAA_AAAA, 1'b0, '{54'd0, 1'b0}},
    '{53'd1,               1'b0, '{54'd0, 1'b0}}
  };

  logic clk;
  logic rst;

  emc_sig_if  operand_if ();
  emc_cube_if result_if ();
  emc_cfg_if  cfg_if ();

  exact_mantissa_cube_core #(
    .SIG_WIDTH (SIG_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_if),
    .result  (result_if),
    .cfg     (cfg_if)
  );

  cube_res_t        pending_cubes [$];
  round_mode_t      round_mode;
  logic [SIG_W-1:0] cbrt_edge [2];
  int unsigned      mismatches;
  int unsigned      cycle_count;
  bit               operand_quiet;
  bit               result_quiet;
  bit               hold_off_req;

  // Cube the significand with its hidden one forced and keep the top bits
  function automatic cube_res_t cube_top_bits(input logic [SIG_W-1:0] sig,
                                              input round_mode_t mode);
    logic [CUBE_W-1:0]      wide;
    logic [CUBE_W-1:0]      cube;
    logic [CUBE_PORT_W-1:0] top;
    int                     lead;
    cube_res_t              res;
    wide = CUBE_W'(sig | (SIG_W'(1) << (SIG_W - 1)));
    cube = wide * wide * wide;
    lead = CUBE_W - 1;
    while (lead > 0 && !cube[lead]) lead--;
    top = CUBE_PORT_W'(cube >> (lead - (SIG_W - 1)));
    if (mode == MODE_ROUND) begin
      top = top + CUBE_PORT_W'(cube[lead - SIG_W]);
    end
    res.cube_significand = top;
    res.round_overflow   = top[SIG_W];
    return res;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_MAX) begin
      $display("%0t: timeout with %0d results pending", $time, pending_cubes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one operand, optionally after an idle burst, and record its cube
  task automatic send_significand(input logic [SIG_W-1:0] sig, input bit typed,
                                  input cube_res_t want);
    if (!operand_quiet && $urandom_range(0, 3) == 0) begin
      operand_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    operand_if.valid       <= 1'b1;
    operand_if.significand <= sig;
    do @(posedge clk); while (!operand_if.ready);
    pending_cubes.push_back(typed ? want : cube_top_bits(sig, round_mode));
  endtask

  // Drain the pipeline, then write the rounding mode
  task automatic write_round_mode(input round_mode_t mode);
    operand_if.valid <= 1'b0;
    while (pending_cubes.size() != 0) @(posedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.round_enable <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    round_mode = mode;
  endtask

  // Walk the directed table, then the cube-root boundary neighbors
  task automatic run_directed();
    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_significand(DIRECTED[i].significand, DIRECTED[i].typed, DIRECTED[i].want);
    end
    for (int e = 0; e < 2; e++) begin
      send_significand(cbrt_edge[e], 1'b0, '0);
      send_significand(cbrt_edge[e] + SIG_W'(1), 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, one long hold-off, none at the end
  initial begin
    result_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!result_quiet && (cycle_count % 256) < 160
                   && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result with the oldest pending cube
  always @(posedge clk) begin
    cube_res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_cubes.size() == 0) begin
        $display("%0t: unexpected result cube %h overflow %b", $time,
                 result_if.cube_significand, result_if.round_overflow);
        mismatches++;
      end else begin
        want = pending_cubes.pop_front();
        if (result_if.cube_significand !== want.cube_significand) begin
          $display("%0t: cube_significand expected %h actual %h", $time,
                   want.cube_significand, result_if.cube_significand);
          mismatches++;
        end
        if (result_if.round_overflow !== want.round_overflow) begin
          $display("%0t: round_overflow expected %b actual %b", $time,
                   want.round_overflow, result_if.round_overflow);
          mismatches++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [SIG_W-1:0]  lo;
    logic [SIG_W-1:0]  hi;
    logic [SIG_W-1:0]  mid;
    logic [SIG_W-1:0]  sig;
    logic [CUBE_W-1:0] wide;
    round_mode_t       phase_mode [4];

    rst                    <= 1'b1;
    operand_if.valid       <= 1'b0;
    operand_if.significand <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.round_enable    <= 1'b0;
    cycle_count            = 0;
    mismatches             = 0;
    operand_quiet          = 1'b0;
    result_quiet           = 1'b0;
    hold_off_req           = 1'b0;
    round_mode             = MODE_ROUND;
    phase_mode             = '{MODE_ROUND, MODE_TRUNCATE, MODE_ROUND, MODE_TRUNCATE};

    // Find the largest significand whose cube stays below 2^157 and 2^158
    for (int e = 0; e < 2; e++) begin
      lo = SIG_MIN;
      hi = SIG_MAX;
      while (lo < hi) begin
        mid  = lo + ((hi - lo + SIG_W'(1)) >> 1);
        wide = CUBE_W'(mid);
        if (wide * wide * wide < (CUBE_W'(1) << (CUBE_W - 2 + e))) lo = mid;
        else hi = mid - SIG_W'(1);
      end
      cbrt_edge[e] = lo;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset mode first, then truncation
    run_directed();
    write_round_mode(MODE_TRUNCATE);
    run_directed();

    // Random part across mode settings; the last phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      write_round_mode(phase_mode[ph]);
      if (ph == 3) begin
        operand_quiet = 1'b1;
        result_quiet  = 1'b1;
      end
      for (int n = 0; n < RAND_PHASE; n++) begin
        if (ph == 1 && n == 50) hold_off_req = 1'b1;
        if (ph < 3 && n % 100 == 0) operand_quiet = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 9))
          0: sig = cbrt_edge[$urandom_range(0, 1)] - SIG_W'(64)
                   + SIG_W'($urandom_range(0, 128));
          1: begin
            sig = SIG_W'(1) << $urandom_range(0, SIG_W - 1);
            if ($urandom_range(0, 1) == 1) sig = ~sig;
          end
          2, 3: sig = SIG_W'({$urandom, $urandom}) | SIG_MIN;
          default: sig = SIG_W'({$urandom, $urandom});
        endcase
        send_significand(sig, 1'b0, '0);
      end
    end
    operand_if.valid <= 1'b0;

    // Wait out the remaining results, then a few more cycles for strays
    while (pending_cubes.size() != 0) @(posedge clk);
    repeat (4 * NUM_STAGES) @(posedge clk);
    if (mismatches == 0 && pending_cubes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: exact_mantissa_cube_core.f
sv/emc_pkg.sv
sv/emc_if.sv
sv/emc_round.sv
sv/exact_mantissa_cube_core.sv
sv/emc_checker.sv
sim/exact_mantissa_cube_core_tb.sv
